// ===== rtl/mcg_pkg.sv =====
// Shared types and constants for the midpoint circle generator.
package mcg_pkg;

    localparam int COORD_BITS = 12;
    localparam int CLIP_W     = 19;
    localparam int DEC_W      = 18;
    localparam int STEP_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [12:0] BOUND_LIM = 13'(1 << COORD_BITS);

    localparam logic signed [DEC_W-1:0] DEC_INIT = 18'sd3;
    localparam logic signed [DEC_W-1:0] DEC_MUL  = 18'sd4;
    localparam logic signed [DEC_W-1:0] DEC_DIAG = 18'sd10;
    localparam logic signed [DEC_W-1:0] DEC_AXIS = 18'sd6;
    // x and y move before the update is applied, so fold their +1/-1 into the constant
    localparam logic signed [DEC_W-1:0] DEC_DIAG_STEP = DEC_DIAG + 18'sd2 * DEC_MUL;
    localparam logic signed [DEC_W-1:0] DEC_AXIS_STEP = DEC_AXIS + DEC_MUL;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLIP_LEFT   = 3'd0,
        REG_CLIP_TOP    = 3'd1,
        REG_CLIP_RIGHT  = 3'd2,
        REG_CLIP_BOTTOM = 3'd3,
        REG_FILL_MODE   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic        [11:0] radius;
    } in_item_t;

    typedef struct packed {
        logic [11:0] pix_x;
        logic [11:0] pix_y;
        logic [12:0] span_len;
        logic        last;
    } out_item_t;

    // one circle position queued between front and back
    typedef struct packed {
        logic signed [15:0]       cx;
        logic signed [15:0]       cy;
        logic signed [STEP_W-1:0] sx;
        logic signed [STEP_W-1:0] sy;
        logic                     fill;
        logic                     is_final;
    } pos_t;

    typedef struct packed {
        logic [11:0] left;
        logic [11:0] top;
        logic [12:0] right;
        logic [12:0] bottom;
    } clip_cfg_t;

endpackage

// ===== rtl/mcg_front.sv =====
// Front end: takes item beats, runs the midpoint stepping, queues positions.
module mcg_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  mcg_pkg::in_item_t item,
    input  logic              fill_mode,
    input  logic              q_full,
    output logic              q_push,
    output mcg_pkg::pos_t     q_data
);
    import mcg_pkg::*;

    logic signed [15:0]       ctr_x_reg, ctr_x_next;
    logic signed [15:0]       ctr_y_reg, ctr_y_next;
    logic signed [STEP_W-1:0] step_x_reg, step_x_next;
    logic signed [STEP_W-1:0] step_y_reg, step_y_next;
    logic signed [DEC_W-1:0]  dec_reg, dec_next;
    logic                     active_reg, active_next;

    logic                     accept;
    logic                     is_final;
    logic signed [STEP_W:0]   diff;
    logic signed [DEC_W-1:0]  diff4;
    logic signed [DEC_W-1:0]  x4;

    assign item_ready = !q_full;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        ctr_x_next  = ctr_x_reg;
        ctr_y_next  = ctr_y_reg;
        step_x_next = step_x_reg;
        step_y_next = step_y_reg;
        dec_next    = dec_reg;
        active_next = active_reg;
        is_final    = 1'b0;
        q_push      = 1'b0;

        diff  = $signed({step_x_reg[STEP_W-1], step_x_reg})
              - $signed({step_y_reg[STEP_W-1], step_y_reg});
        diff4 = $signed({{(DEC_W-STEP_W-1){diff[STEP_W]}}, diff}) <<< 2;
        x4    = $signed({{(DEC_W-STEP_W){step_x_reg[STEP_W-1]}}, step_x_reg}) <<< 2;

        if (accept)
        begin
            if (item.cmd == CMD_START)
            begin
                ctr_x_next  = item.center_x;
                ctr_y_next  = item.center_y;
                step_x_next = '0;
                step_y_next = $signed({1'b0, item.radius});
                dec_next    = DEC_INIT - $signed({5'b0, item.radius, 1'b0});
                active_next = 1'b1;
                q_push      = 1'b1;
            end
            else if (active_reg)
            begin
                step_x_next = step_x_reg + 13'sd1;
                if (dec_reg > 0)
                begin
                    step_y_next = step_y_reg - 13'sd1;
                    dec_next    = dec_reg + diff4 + DEC_DIAG_STEP;
                end
                else
                begin
                    dec_next = dec_reg + x4 + DEC_AXIS_STEP;
                end
                is_final    = step_y_next < step_x_next;
                active_next = !is_final;
                q_push      = 1'b1;
            end
        end
    end

    assign q_data = '{cx: ctr_x_next, cy: ctr_y_next, sx: step_x_next, sy: step_y_next,
                      fill: fill_mode, is_final: is_final};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_x_reg  <= '0;
            ctr_y_reg  <= '0;
            step_x_reg <= '0;
            step_y_reg <= '0;
            dec_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            ctr_x_reg  <= ctr_x_next;
            ctr_y_reg  <= ctr_y_next;
            step_x_reg <= step_x_next;
            step_y_reg <= step_y_next;
            dec_reg    <= dec_next;
            active_reg <= active_next;
        end
    end

endmodule

// ===== rtl/mcg_queue.sv =====
// Small position queue between front and back.
module mcg_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mcg_pkg::pos_t push_data,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output mcg_pkg::pos_t head
);
    import mcg_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0]   PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CNTW-1:0] CNT_FULL = CNTW'(DEPTH);

    pos_t            mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0] count_reg;
    logic            do_push, do_pop;

    assign full       = count_reg == CNT_FULL;
    assign head_valid = count_reg != '0;
    assign head       = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/mcg_back.sv =====
// Back end: walks the symmetric points or spans of each position, clips, emits results.
module mcg_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  mcg_pkg::pos_t       q_head,
    output logic                q_pop,
    input  mcg_pkg::clip_cfg_t  clip,
    output logic                result_valid,
    input  logic                result_ready,
    output mcg_pkg::out_item_t  result
);
    import mcg_pkg::*;

    localparam logic [2:0] OUTLINE_LAST = 3'd7;
    localparam logic [2:0] FILL_LAST    = 3'd3;
    localparam logic signed [CLIP_W-1:0] ONE = 19'sd1;

    // candidate counter
    logic [2:0] idx_reg;
    logic       swap, ysign, use_hi, last_idx, issue;
    logic signed [CLIP_W-1:0] cx_s, cy_s, u_s, v_s, lo, hi, py_raw;

    // registered candidate
    logic                     a_valid_reg;
    logic signed [CLIP_W-1:0] a_px_reg, a_end_reg, a_py_reg;
    logic                     a_point_reg, a_last_reg, a_final_reg;

    // clip
    logic [12:0]              right_lim, bottom_lim;
    logic signed [CLIP_W-1:0] left_s, top_s, right_s, bottom_s, cpx, clen;
    logic                     py_ok, keep, a_go;
    out_item_t                cand;

    // hold one kept result until it is known whether it ends the circle
    out_item_t hold_reg;
    logic      hold_valid_reg, hold_done_reg, hold_move, out_free;
    out_item_t result_reg;
    logic      result_valid_reg;

    always_comb
    begin
        if (q_head.fill)
        begin
            swap     = idx_reg[1];
            ysign    = idx_reg[0];
            use_hi   = 1'b0;
            last_idx = idx_reg == FILL_LAST;
        end
        else
        begin
            swap     = idx_reg[2];
            ysign    = idx_reg[1];
            use_hi   = idx_reg[0];
            last_idx = idx_reg == OUTLINE_LAST;
        end
        cx_s = CLIP_W'(q_head.cx);
        cy_s = CLIP_W'(q_head.cy);
        u_s  = swap ? CLIP_W'(q_head.sy) : CLIP_W'(q_head.sx);
        v_s  = swap ? CLIP_W'(q_head.sx) : CLIP_W'(q_head.sy);
        lo     = cx_s - u_s;
        hi     = cx_s + u_s;
        py_raw = ysign ? cy_s - v_s : cy_s + v_s;
    end

    assign issue = q_valid && (!a_valid_reg || a_go);
    assign q_pop = issue && last_idx;

    always_comb
    begin
        right_lim  = (clip.right > BOUND_LIM) ? BOUND_LIM : clip.right;
        bottom_lim = (clip.bottom > BOUND_LIM) ? BOUND_LIM : clip.bottom;
        left_s     = $signed({{(CLIP_W-12){1'b0}}, clip.left});
        top_s      = $signed({{(CLIP_W-12){1'b0}}, clip.top});
        right_s    = $signed({{(CLIP_W-13){1'b0}}, right_lim});
        bottom_s   = $signed({{(CLIP_W-13){1'b0}}, bottom_lim});
        py_ok      = (a_py_reg >= top_s) && (a_py_reg < bottom_s);
        if (a_point_reg)
        begin
            cpx  = a_px_reg;
            clen = ONE;
            keep = py_ok && (a_px_reg >= left_s) && (a_px_reg < right_s);
        end
        else
        begin
            // cutting at the left edge keeps the right end where it was
            cpx  = (a_px_reg < left_s) ? left_s : a_px_reg;
            clen = (a_end_reg >= right_s) ? right_s - cpx - ONE : a_end_reg - cpx;
            keep = py_ok && (clen > 0);
        end
        cand.pix_x    = cpx[11:0];
        cand.pix_y    = a_py_reg[11:0];
        cand.span_len = clen[12:0];
        cand.last     = a_last_reg && a_final_reg;
    end

    assign out_free  = !result_valid_reg || result_ready;
    assign hold_move = hold_valid_reg && out_free
                     && (hold_done_reg || (a_valid_reg && keep));
    assign a_go      = a_valid_reg && (!keep || !hold_valid_reg || hold_move);

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            a_px_reg    <= use_hi ? hi : lo;
            a_end_reg   <= hi;
            a_py_reg    <= py_raw;
            a_point_reg <= !q_head.fill;
            a_last_reg  <= last_idx;
            a_final_reg <= q_head.is_final;
        end
        if (a_go && keep)
        begin
            hold_reg <= cand;
        end
        else if (a_go && a_last_reg && hold_valid_reg && !hold_done_reg)
        begin
            hold_reg.last <= a_final_reg;
        end
        if (hold_move)
        begin
            result_reg <= hold_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg          <= '0;
            a_valid_reg      <= 1'b0;
            hold_valid_reg   <= 1'b0;
            hold_done_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                idx_reg <= last_idx ? '0 : idx_reg + 3'd1;
            end

            if (issue)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_go)
            begin
                a_valid_reg <= 1'b0;
            end

            if (a_go && keep)
            begin
                hold_valid_reg <= 1'b1;
                hold_done_reg  <= a_last_reg;
            end
            else if (hold_move)
            begin
                hold_valid_reg <= 1'b0;
                hold_done_reg  <= 1'b0;
            end
            else if (a_go && a_last_reg && hold_valid_reg)
            begin
                hold_done_reg <= 1'b1;
            end

            if (hold_move)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/midpoint_circle_generator.sv =====
// Top level of the midpoint circle generator: clip registers, front, queue, back.
// A start beat loads center and radius and yields the points of x = 0; each step
// beat advances one position. The front takes one item beat per cycle while the
// position queue (QUEUE_DEPTH entries) has room. The back walks each position with
// a 3-bit candidate counter, one candidate per cycle while its output is not
// stalled: an outline position has 8 candidates and a fill position 4. Results
// leave at up to one beat per cycle. The first kept result of an item passes the
// position queue, the candidate register, the hold stage and the result register;
// a kept result waits in the one-entry hold stage until the next kept candidate or
// the position's last candidate is checked. Clipped candidates are still walked.
// The last flag rides on the final kept result of the closing step. The user must
// write configuration only while the block is idle; the block does not enforce it.
module midpoint_circle_generator #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  mcg_pkg::in_item_t                   item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output mcg_pkg::out_item_t                  result,
    input  logic                                cfg_we,
    input  logic [mcg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mcg_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import mcg_pkg::*;

    logic [11:0] clip_left_reg;
    logic [11:0] clip_top_reg;
    logic [12:0] clip_right_reg;
    logic [12:0] clip_bottom_reg;
    logic        fill_mode_reg;

    clip_cfg_t   clip;
    logic        q_full, q_push, q_pop, q_valid;
    pos_t        q_data, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_right_reg  <= BOUND_LIM;
            clip_bottom_reg <= BOUND_LIM;
            fill_mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CLIP_LEFT:   clip_left_reg   <= cfg_data[11:0];
                REG_CLIP_TOP:    clip_top_reg    <= cfg_data[11:0];
                REG_CLIP_RIGHT:  clip_right_reg  <= cfg_data;
                REG_CLIP_BOTTOM: clip_bottom_reg <= cfg_data;
                REG_FILL_MODE:   fill_mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign clip = '{left: clip_left_reg, top: clip_top_reg,
                    right: clip_right_reg, bottom: clip_bottom_reg};

    mcg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .fill_mode  (fill_mode_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_data)
    );

    mcg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_data),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_head)
    );

    mcg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .clip         (clip),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== rtl/mcg_checker.sv =====
// Port-level checks for the midpoint circle generator, bound to the top level.
module mcg_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic                result_valid,
    input logic                result_ready,
    input mcg_pkg::out_item_t  result
);
    import mcg_pkg::*;

    logic seen_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_item_reg <= 1'b0;
        end
        else if (item_valid && item_ready)
        begin
            seen_item_reg <= 1'b1;
        end
    end

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result payload changed while stalled");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.span_len != '0) && (result.span_len <= BOUND_LIM))
        else $error("result span length out of range");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> seen_item_reg)
        else $error("result beat without any accepted item");

endmodule

bind midpoint_circle_generator mcg_checker u_mcg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
